// ----- sv/weighted_sum_tree_sampler_unit_macros.svh -----
// Assertion macros shared by the sum-tree sampler RTL.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef WEIGHTED_SUM_TREE_SAMPLER_UNIT_MACROS_SVH
`define WEIGHTED_SUM_TREE_SAMPLER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define WSTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define WSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WSTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/wsts_pkg.sv -----
// Shared constants and types of the sum-tree sampler.
// No dependencies.
package wsts_pkg;
	localparam int LEAF_BITS_DEF   = 10;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int SUM_W           = 48;
	localparam int WEIGHT_W        = 32;
	localparam int DRAW_W          = 64;
	localparam int REQ_W           = 2;
	localparam int STATUS_W        = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_SELECT = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic lo_en;
		logic hi_en;
		logic sat_en;
	} mul_ctl_t;
endpackage

// ----- sv/weighted_sum_tree_sampler_unit.sv -----
// Sum-tree weighted sampler: insert, remove, update and select over 2^LEAF_BITS slots.
// Depends on wsts_pkg, wsts_mul and weighted_sum_tree_sampler_unit_macros.svh.
// One request at a time walks the tree one level per step through a single-port node
// memory (read, then write back). Each select level runs the shared multiplier through its
// low, high and saturate steps before the compare. After reset a clearing pass over all
// 2^LEAF_BITS entries zeroes the tree and the request side stays stalled meanwhile.
// A finished result sits in an output register, so the next request is taken while it waits.
`include "weighted_sum_tree_sampler_unit_macros.svh"
module weighted_sum_tree_sampler_unit #(
	parameter int LEAF_BITS   = wsts_pkg::LEAF_BITS_DEF,
	parameter int HANDLE_BITS = wsts_pkg::HANDLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [wsts_pkg::REQ_W-1:0]      req_type,
	input  logic [LEAF_BITS-1:0]            slot,
	input  logic [wsts_pkg::WEIGHT_W-1:0]   weight,
	input  logic [HANDLE_BITS-1:0]          handle,
	input  logic [wsts_pkg::DRAW_W-1:0]     draw,
	input  logic [wsts_pkg::WEIGHT_W-1:0]   base_rate,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [LEAF_BITS-1:0]            result_slot,
	output logic [HANDLE_BITS-1:0]          result_handle,
	output logic [wsts_pkg::SUM_W-1:0]      total_weight,
	output logic [LEAF_BITS:0]              occupied,
	output logic [wsts_pkg::STATUS_W-1:0]   status
);
	import wsts_pkg::*;

	localparam int LEAVES = 1 << LEAF_BITS;
	localparam int CNT_W  = LEAF_BITS + 1;
	localparam int NODE_W = SUM_W + 2 * CNT_W;
	localparam int LEAF_W = WEIGHT_W + 1;

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_LEAF_RD  = 4'd2;
	localparam logic [3:0] S_LEAF_CHK = 4'd3;
	localparam logic [3:0] S_NODE_RD  = 4'd4;
	localparam logic [3:0] S_NODE_EV  = 4'd5;
	localparam logic [3:0] S_MUL_LO   = 4'd6;
	localparam logic [3:0] S_MUL_HI   = 4'd7;
	localparam logic [3:0] S_MUL_SAT  = 4'd8;
	localparam logic [3:0] S_SEL_CMP  = 4'd9;
	localparam logic [3:0] S_LEAF_WR  = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	logic [3:0]             state_q;
	logic [LEAF_BITS-1:0]   clr_q;
	logic [REQ_W-1:0]       op_q;
	logic [LEAF_BITS-1:0]   slot_q;
	logic [WEIGHT_W-1:0]    w_q;
	logic [HANDLE_BITS-1:0] h_q;
	logic [DRAW_W-1:0]      draw_q;
	logic [WEIGHT_W-1:0]    rate_q;
	logic [WEIGHT_W-1:0]    old_q;
	logic [LEAF_BITS:0]     node_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       occ_q;
	logic [LEAF_BITS-1:0]   res_slot_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic                   rsp_valid_q;
	logic [LEAF_BITS-1:0]   out_slot_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [SUM_W-1:0]       out_total_q;
	logic [CNT_W-1:0]       out_occ_q;
	logic [STATUS_W-1:0]    out_status_q;

	logic [NODE_W-1:0]      node_mem [LEAVES];
	logic [LEAF_W-1:0]      leaf_mem [LEAVES];
	logic [HANDLE_BITS-1:0] handle_mem [LEAVES];
	logic [NODE_W-1:0]      node_rd_q;
	logic [LEAF_W-1:0]      leaf_rd_q;
	logic [HANDLE_BITS-1:0] handle_rd_q;

	logic                   walk_up;
	logic [LEAF_BITS-1:0]   node_addr;
	logic [SUM_W-1:0]       nd_sum;
	logic [CNT_W-1:0]       nd_lc;
	logic [CNT_W-1:0]       nd_rc;
	logic                   go_left;
	logic                   up_last;
	logic [NODE_W-1:0]      node_new;
	logic                   node_we;
	logic [LEAF_BITS-1:0]   node_waddr;
	logic [NODE_W-1:0]      node_wdata;
	logic                   leaf_we;
	logic [LEAF_BITS-1:0]   leaf_waddr;
	logic [LEAF_W-1:0]      leaf_wdata;
	logic                   sel_left;
	logic [LEAF_BITS:0]     nxt_down;
	logic                   out_free;
	mul_ctl_t               mul_ctl;
	logic [DRAW_W-1:0]      prod;

	assign walk_up   = (op_q == REQ_REMOVE) || (op_q == REQ_UPDATE);
	assign node_addr = walk_up ? node_q[LEAF_BITS:1] : node_q[LEAF_BITS-1:0];
	assign nd_sum    = node_rd_q[SUM_W-1:0];
	assign nd_lc     = node_rd_q[SUM_W +: CNT_W];
	assign nd_rc     = node_rd_q[SUM_W+CNT_W +: CNT_W];
	assign go_left   = nd_lc <= nd_rc;
	assign up_last   = node_q[LEAF_BITS:1] == LEAF_BITS'(1);
	assign sel_left  = draw_q <= prod;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign nxt_down  = {node_q[LEAF_BITS-1:0],
		(state_q == S_SEL_CMP) ? !sel_left : !go_left};

	always_comb begin
		node_new = node_rd_q;
		unique case (op_q)
			REQ_INSERT: begin
				if (go_left) begin
					node_new = {nd_rc, nd_lc + CNT_W'(1), nd_sum + SUM_W'(w_q)};
				end else begin
					node_new = {nd_rc + CNT_W'(1), nd_lc, nd_sum};
				end
			end
			REQ_REMOVE: begin
				if (!node_q[0]) begin
					node_new = {nd_rc, nd_lc - CNT_W'(1), nd_sum - SUM_W'(old_q)};
				end else begin
					node_new = {nd_rc - CNT_W'(1), nd_lc, nd_sum};
				end
			end
			REQ_UPDATE: begin
				if (!node_q[0]) begin
					node_new = {nd_rc, nd_lc, nd_sum - SUM_W'(old_q) + SUM_W'(w_q)};
				end
			end
			default: begin
				node_new = node_rd_q;
			end
		endcase
	end

	always_comb begin
		node_we    = 1'b0;
		node_waddr = node_addr;
		node_wdata = node_new;
		leaf_we    = 1'b0;
		leaf_waddr = slot_q;
		leaf_wdata = {1'b1, w_q};
		if (state_q == S_CLEAR) begin
			node_we    = 1'b1;
			node_waddr = clr_q;
			node_wdata = '0;
			leaf_we    = 1'b1;
			leaf_waddr = clr_q;
			leaf_wdata = '0;
		end else if (state_q == S_NODE_EV) begin
			node_we = 1'b1;
			if (walk_up && up_last) begin
				leaf_we    = 1'b1;
				leaf_wdata = (op_q == REQ_REMOVE) ? '0 : {1'b1, w_q};
			end
		end else if (state_q == S_LEAF_WR) begin
			leaf_we    = 1'b1;
			leaf_waddr = node_q[LEAF_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem[node_addr];
	end

	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_waddr] <= leaf_wdata;
		end
		leaf_rd_q <= leaf_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LEAF_WR) begin
			handle_mem[node_q[LEAF_BITS-1:0]] <= h_q;
		end
		handle_rd_q <= handle_mem[slot_q];
	end

	assign mul_ctl.lo_en  = state_q == S_MUL_LO;
	assign mul_ctl.hi_en  = state_q == S_MUL_HI;
	assign mul_ctl.sat_en = state_q == S_MUL_SAT;

	wsts_mul u_mul (
		.clk  (clk),
		.ctl  (mul_ctl),
		.sum  (nd_sum),
		.rate (rate_q),
		.prod (prod)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			op_q         <= req_type;
			slot_q       <= slot;
			w_q          <= weight;
			h_q          <= handle;
			draw_q       <= draw;
			rate_q       <= base_rate;
			res_handle_q <= '0;
			res_status_q <= (req_type == REQ_INSERT && occ_q == CNT_W'(LEAVES)) ?
				ST_FULL : ST_OK;
			res_slot_q   <= (req_type == REQ_INSERT) ? '0 : slot;
			node_q <= (req_type == REQ_REMOVE || req_type == REQ_UPDATE) ?
				{1'b1, slot} : (LEAF_BITS+1)'(1);
		end
		if (state_q == S_LEAF_CHK) begin
			res_slot_q <= slot_q;
			if (!leaf_rd_q[WEIGHT_W]) begin
				res_status_q <= ST_EMPTY;
			end else begin
				res_handle_q <= handle_rd_q;
				old_q        <= leaf_rd_q[WEIGHT_W-1:0];
			end
		end
		if (state_q == S_NODE_EV) begin
			node_q <= walk_up ? {1'b0, node_q[LEAF_BITS:1]} : nxt_down;
		end
		if (state_q == S_SEL_CMP) begin
			node_q <= nxt_down;
			slot_q <= nxt_down[LEAF_BITS-1:0];
			if (!sel_left) begin
				draw_q <= draw_q - prod;
			end
		end
		if (state_q == S_LEAF_WR) begin
			res_slot_q   <= node_q[LEAF_BITS-1:0];
			res_handle_q <= h_q;
		end
		if (state_q == S_DONE && out_free) begin
			out_slot_q   <= res_slot_q;
			out_handle_q <= res_handle_q;
			out_status_q <= res_status_q;
			out_total_q  <= sum_q;
			out_occ_q    <= occ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sum_q       <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= (rsp_valid_q && rsp_stall) || (state_q == S_DONE && out_free);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + LEAF_BITS'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						priority if (req_type == REQ_INSERT && occ_q == CNT_W'(LEAVES)) begin
							state_q <= S_DONE;
						end else if (req_type == REQ_REMOVE || req_type == REQ_UPDATE) begin
							state_q <= S_LEAF_RD;
						end else begin
							state_q <= S_NODE_RD;
						end
					end
				end
				S_LEAF_RD: begin
					state_q <= S_LEAF_CHK;
				end
				S_LEAF_CHK: begin
					if (op_q == REQ_SELECT || !leaf_rd_q[WEIGHT_W]) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NODE_RD;
					end
				end
				S_NODE_RD: begin
					state_q <= (op_q == REQ_SELECT) ? S_MUL_LO : S_NODE_EV;
				end
				S_MUL_LO: begin
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					state_q <= S_MUL_SAT;
				end
				S_MUL_SAT: begin
					state_q <= S_SEL_CMP;
				end
				S_SEL_CMP: begin
					state_q <= nxt_down[LEAF_BITS] ? S_LEAF_RD : S_NODE_RD;
				end
				S_NODE_EV: begin
					if (walk_up) begin
						if (up_last) begin
							state_q <= S_DONE;
							occ_q   <= (op_q == REQ_REMOVE) ? occ_q - CNT_W'(1) : occ_q;
							if (op_q == REQ_REMOVE) begin
								sum_q <= (occ_q <= CNT_W'(1)) ? '0 : sum_q - SUM_W'(old_q);
							end else begin
								sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(w_q);
							end
						end else begin
							state_q <= S_NODE_RD;
						end
					end else begin
						state_q <= nxt_down[LEAF_BITS] ? S_LEAF_WR : S_NODE_RD;
					end
				end
				S_LEAF_WR: begin
					sum_q   <= sum_q + SUM_W'(w_q);
					occ_q   <= occ_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall     = state_q != S_IDLE;
	assign rsp_valid     = rsp_valid_q;
	assign result_slot   = out_slot_q;
	assign result_handle = out_handle_q;
	assign total_weight  = out_total_q;
	assign occupied      = out_occ_q;
	assign status        = out_status_q;

	`WSTS_ASSERT_IMPL(a_occ_range, clk, arst_n, 1'b1, occ_q <= CNT_W'(LEAVES))
	`WSTS_ASSERT_IMPL(a_empty_total, clk, arst_n, occ_q == '0, sum_q == '0)
	`WSTS_ASSERT_IMPL(a_err_handle, clk, arst_n, rsp_valid && status != ST_OK, result_handle == '0)
	`WSTS_ASSERT_IMPL(a_full_occ, clk, arst_n, rsp_valid && status == ST_FULL, occupied == CNT_W'(LEAVES))
	`WSTS_ASSERT_NEXT(a_done_out, clk, arst_n, state_q == S_DONE && out_free, rsp_valid && state_q == S_IDLE)
endmodule

// ----- sv/wsts_mul.sv -----
// Shared 32x32 multiplier forming a saturated 48x32 product in three steps.
// Depends on wsts_pkg.
module wsts_mul (
	input  logic                               clk,
	input  wsts_pkg::mul_ctl_t                 ctl,
	input  logic [wsts_pkg::SUM_W-1:0]         sum,
	input  logic [wsts_pkg::WEIGHT_W-1:0]      rate,
	output logic [wsts_pkg::DRAW_W-1:0]        prod
);
	import wsts_pkg::*;

	localparam int HI_W = SUM_W - WEIGHT_W;

	logic [WEIGHT_W-1:0]      mul_a;
	logic [2*WEIGHT_W-1:0]    mul_p;
	logic [2*WEIGHT_W-1:0]    prod_lo_q;
	logic [HI_W+WEIGHT_W-1:0] prod_hi_q;
	logic [DRAW_W:0]          wide;
	logic                     ovf;
	logic [DRAW_W-1:0]        prod_q;

	assign mul_a = ctl.hi_en ? WEIGHT_W'(sum[SUM_W-1:WEIGHT_W]) : sum[WEIGHT_W-1:0];
	assign mul_p = (2*WEIGHT_W)'(mul_a) * (2*WEIGHT_W)'(rate);
	assign ovf   = |prod_hi_q[HI_W+WEIGHT_W-1:WEIGHT_W];
	assign wide  = (DRAW_W+1)'(prod_lo_q) + {1'b0, prod_hi_q[WEIGHT_W-1:0], {WEIGHT_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (ctl.lo_en) begin
			prod_lo_q <= mul_p;
		end
		if (ctl.hi_en) begin
			prod_hi_q <= mul_p[HI_W+WEIGHT_W-1:0];
		end
		if (ctl.sat_en) begin
			prod_q <= (ovf || wide[DRAW_W]) ? '1 : wide[DRAW_W-1:0];
		end
	end

	assign prod = prod_q;
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of weighted_sum_tree_sampler_unit: directed, fill/drain and random
// requests, with a built-in model of the sum tree that predicts every result in order.
// Depends on wsts_pkg and the RTL of the unit only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wsts_pkg::*;

	localparam int LEAVES = 1024;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [9:0]  slot_idx;
		logic [15:0] hdl;
		logic [47:0] total;
		logic [10:0] count;
		logic [1:0]  st;
	} tree_result_t;

	logic        clk, arst_n;
	logic        req_valid, req_stall, rsp_valid, rsp_stall;
	logic [1:0]  req_type;
	logic [9:0]  slot;
	logic [31:0] weight;
	logic [15:0] handle;
	logic [63:0] draw;
	logic [31:0] base_rate;
	logic [9:0]  result_slot;
	logic [15:0] result_handle;
	logic [47:0] total_weight;
	logic [10:0] occupied;
	logic [1:0]  status;

	logic [47:0] mdl_left_sum[LEAVES];
	int unsigned mdl_left_cnt[LEAVES];
	int unsigned mdl_right_cnt[LEAVES];
	logic [31:0] mdl_weight[LEAVES];
	logic [15:0] mdl_handle[LEAVES];
	bit          mdl_used[LEAVES];
	logic [47:0] mdl_total;
	int unsigned mdl_count;

	tree_result_t pending_results[$];
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	bit quiet = 0;
	int long_hold = 0;

	weighted_sum_tree_sampler_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] scaled_sum(logic [47:0] s, logic [31:0] r);
		logic [79:0] p;
		p = s * r;
		return (p[79:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
	endfunction

	function automatic tree_result_t apply_request(logic [1:0] kind, logic [9:0] s,
			logic [31:0] w, logic [15:0] h, logic [63:0] d, logic [31:0] r);
		tree_result_t res;
		int unsigned node;
		logic [31:0] old;
		logic [63:0] p;
		res = '{slot_idx: '0, hdl: '0, total: '0, count: '0, st: ST_OK};
		case (kind)
			REQ_INSERT: begin
				if (mdl_count >= LEAVES) begin
					res.st = ST_FULL;
				end else begin
					node = 1;
					while (node < LEAVES) begin
						if (mdl_left_cnt[node] <= mdl_right_cnt[node]) begin
							mdl_left_cnt[node]++;
							mdl_left_sum[node] = mdl_left_sum[node] + w;
							node = 2 * node;
						end else begin
							mdl_right_cnt[node]++;
							node = 2 * node + 1;
						end
					end
					res.slot_idx = 10'(node - LEAVES);
					mdl_weight[res.slot_idx] = w;
					mdl_handle[res.slot_idx] = h;
					mdl_used[res.slot_idx] = 1;
					mdl_total = mdl_total + w;
					mdl_count++;
					res.hdl = h;
				end
			end
			REQ_REMOVE, REQ_UPDATE: begin
				res.slot_idx = s;
				if (!mdl_used[s]) begin
					res.st = ST_EMPTY;
				end else begin
					old = mdl_weight[s];
					res.hdl = mdl_handle[s];
					node = s + LEAVES;
					while (node > 1) begin
						if (node % 2 == 0) begin
							if (kind == REQ_REMOVE) mdl_left_cnt[node/2]--;
							mdl_left_sum[node/2] = mdl_left_sum[node/2] - old
								+ ((kind == REQ_UPDATE) ? w : 32'd0);
						end else if (kind == REQ_REMOVE) begin
							mdl_right_cnt[node/2]--;
						end
						node = node / 2;
					end
					if (kind == REQ_REMOVE) begin
						mdl_total = (mdl_count <= 1) ? '0 : mdl_total - old;
						mdl_weight[s] = '0;
						mdl_used[s] = 0;
						mdl_count--;
					end else begin
						mdl_total = mdl_total - old + w;
						mdl_weight[s] = w;
					end
				end
			end
			default: begin
				node = 1;
				while (node < LEAVES) begin
					p = scaled_sum(mdl_left_sum[node], r);
					if (d <= p) begin
						node = 2 * node;
					end else begin
						d = d - p;
						node = 2 * node + 1;
					end
				end
				res.slot_idx = 10'(node - LEAVES);
				if (mdl_used[res.slot_idx]) res.hdl = mdl_handle[res.slot_idx];
				else res.st = ST_EMPTY;
			end
		endcase
		res.total = mdl_total;
		res.count = 11'(mdl_count);
		return res;
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
	endtask

	task automatic send(logic [1:0] kind, logic [9:0] s, logic [31:0] w, logic [15:0] h,
			logic [63:0] d, logic [31:0] r);
		req_valid <= 1'b1;
		req_type <= kind;
		slot <= s;
		weight <= w;
		handle <= h;
		draw <= d;
		base_rate <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_results.push_back(apply_request(kind, s, w, h, d, r));
		requests_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [9:0] pick_used_slot();
		int unsigned start;
		start = $urandom_range(0, LEAVES - 1);
		for (int i = 0; i < LEAVES; i++)
			if (mdl_used[(start + i) % LEAVES]) return 10'((start + i) % LEAVES);
		return 10'(start);
	endfunction

	task automatic random_request(int unsigned insert_pct);
		int unsigned pick;
		logic [63:0] d;
		pick = $urandom_range(0, 99);
		d = rand64() >> $urandom_range(0, 63);
		if (pick < insert_pct)
			send(REQ_INSERT, 10'($urandom()), $urandom() >> $urandom_range(0, 31),
				16'($urandom()), rand64(), $urandom());
		else if (pick < insert_pct + (100 - insert_pct) / 3)
			send(REQ_REMOVE, ($urandom_range(0, 9) == 0) ? 10'($urandom()) : pick_used_slot(),
				$urandom(), 16'($urandom()), rand64(), $urandom());
		else if (pick < insert_pct + 2 * (100 - insert_pct) / 3)
			send(REQ_UPDATE, ($urandom_range(0, 9) == 0) ? 10'($urandom()) : pick_used_slot(),
				$urandom() >> $urandom_range(0, 31), 16'($urandom()), rand64(), $urandom());
		else
			send(REQ_SELECT, 10'($urandom()), $urandom(), 16'($urandom()), d,
				$urandom() >> $urandom_range(0, 31));
	endtask

	task automatic test_directed();
		send(REQ_SELECT, 10'd0, '0, '0, 64'd0, 32'h0001_0000);
		send(REQ_REMOVE, 10'h3FF, '0, '0, '0, '0);
		send(REQ_UPDATE, 10'd5, 32'hFFFF_FFFF, '0, '0, '0);
		send(REQ_INSERT, 10'h3FF, 32'd0, 16'h0000, '0, '0);
		send(REQ_INSERT, 10'd0, 32'hFFFF_FFFF, 16'hFFFF, '0, '0);
		send(REQ_INSERT, 10'd0, 32'h0001_0000, 16'h1234, '0, '0);
		send(REQ_INSERT, 10'd0, 32'h0000_8000, 16'hABCD, '0, '0);
		send(REQ_SELECT, '0, '0, '0, 64'd0, 32'h0001_0000);
		send(REQ_SELECT, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send(REQ_SELECT, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		send(REQ_SELECT, '0, '0, '0, 64'd1, 32'd0);
		send(REQ_SELECT, '0, '0, '0, 64'h0000_FFFF_0000_0000, 32'h0001_0000);
		send(REQ_UPDATE, 10'd0, 32'hFFFF_FFFF, '0, '0, '0);
		send(REQ_UPDATE, pick_used_slot(), 32'd0, '0, '0, '0);
		send(REQ_SELECT, '0, '0, '0, 64'h0001_0000_0000_0000, 32'h0001_0000);
		while (mdl_count > 0) send(REQ_REMOVE, pick_used_slot(), '0, '0, '0, '0);
		send(REQ_SELECT, '0, '0, '0, 64'd7, 32'hFFFF_FFFF);
	endtask

	task automatic test_fill_and_drain();
		while (mdl_count < LEAVES)
			send(REQ_INSERT, '0, $urandom() >> $urandom_range(0, 31), 16'($urandom()), '0, '0);
		send(REQ_INSERT, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, '0, '0);
		send(REQ_INSERT, 10'h000, 32'h0, 16'h0, '0, '0);
		repeat (20) random_request(0);
		repeat (80) send(REQ_REMOVE, pick_used_slot(), '0, '0, '0, '0);
	endtask

	task automatic test_backpressure();
		long_hold = 300;
		repeat (20) random_request(40);
	endtask

	task automatic test_random();
		repeat (300) random_request(35);
		quiet = 1;
		repeat (100) random_request(35);
	endtask

	initial begin
		tree_result_t want;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					report("unexpected result", 64'(result_slot), 64'd0);
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (result_slot !== want.slot_idx)
						report("result_slot", 64'(result_slot), 64'(want.slot_idx));
					if (result_handle !== want.hdl)
						report("result_handle", 64'(result_handle), 64'(want.hdl));
					if (total_weight !== want.total)
						report("total_weight", 64'(total_weight), 64'(want.total));
					if (occupied !== want.count)
						report("occupied", 64'(occupied), 64'(want.count));
					if (status !== want.st)
						report("status", 64'(status), 64'(want.st));
				end
			end
			if (long_hold > 0) begin
				long_hold--;
				rsp_stall <= 1'b1;
			end else if (rsp_stall && !quiet && $urandom_range(0, 9) != 0) begin
				rsp_stall <= 1'b1;
			end else if (!rsp_stall && !quiet && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", idle_cycles);
				$display("FAIL weighted_sum_tree_sampler_unit");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < LEAVES; i++) begin
			mdl_left_sum[i] = '0;
			mdl_left_cnt[i] = 0;
			mdl_right_cnt[i] = 0;
			mdl_weight[i] = '0;
			mdl_handle[i] = '0;
			mdl_used[i] = 0;
		end
		mdl_total = '0;
		mdl_count = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_type <= REQ_INSERT;
		slot <= '0;
		weight <= '0;
		handle <= '0;
		draw <= '0;
		base_rate <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_drain();
		test_backpressure();
		test_random();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d requests and %0d results: empty, full and drained tree,",
			requests_sent, results_checked);
		$display("saturating selects, empty-slot accesses and a long output hold-off");
		if (errors == 0)
			$display("PASS weighted_sum_tree_sampler_unit");
		else
			$display("FAIL weighted_sum_tree_sampler_unit");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+sv
sv/wsts_pkg.sv
sv/wsts_mul.sv
sv/weighted_sum_tree_sampler_unit.sv
tb/tb.sv
